// ===== rtl/core/fbst_pkg.sv =====
// fbst_pkg: shared constants, types and helpers of the frame buffer slide unit
// used by every module in rtl/core; no dependencies

package fbst_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;

  localparam int XW      = $clog2(SCREEN_WIDTH);
  localparam int YW      = $clog2(SCREEN_HEIGHT);
  localparam int X_SUM_W = XW + 1;
  localparam int Y_SUM_W = YW + 1;
  localparam int ADDR_W  = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);
  localparam int DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int DATA_W  = 16;
  localparam int OFS_W   = 9;
  localparam int STEP_W  = 5;
  localparam int IDX_W   = 5;

  localparam int H_STEPS = 16;
  localparam int V_STEPS = 12;
  localparam int HI_W    = $clog2(H_STEPS);
  localparam int VI_W    = $clog2(V_STEPS);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_LEFT  = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_UP    = 3'd3;
  localparam logic [2:0] DIR_DOWN  = 3'd4;

  localparam logic [STEP_W-1:0] H_TABLE [H_STEPS] = '{
    5'd20, 5'd20, 5'd18, 5'd18, 5'd16, 5'd14, 5'd12, 5'd9,
    5'd6,  5'd6,  5'd4,  5'd4,  5'd3,  5'd3,  5'd2,  5'd2
  };
  localparam logic [STEP_W-1:0] V_TABLE [V_STEPS] = '{
    5'd22, 5'd20, 5'd20, 5'd16, 5'd12, 5'd10, 5'd8, 5'd6,
    5'd4,  5'd3,  5'd2,  5'd2
  };

  typedef struct packed {
    logic              vert;
    logic              desc;
    logic [STEP_W-1:0] amount;
  } sweep_cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [XW-1:0] x,
                                                 input logic [YW-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(SCREEN_WIDTH)) + ADDR_W'(x);
  endfunction

  function automatic logic [STEP_W-1:0] h_step(input logic [IDX_W-1:0] i);
    return (i < IDX_W'(H_STEPS)) ? H_TABLE[i[HI_W-1:0]] : '0;
  endfunction

  function automatic logic [STEP_W-1:0] v_step(input logic [IDX_W-1:0] i);
    return (i < IDX_W'(V_STEPS)) ? V_TABLE[i[VI_W-1:0]] : '0;
  endfunction

endpackage

// ===== rtl/core/fbst_store.sv =====
// fbst_store: pixel memory, one write port and one read port, registered read data
// depends on fbst_pkg

module fbst_store import fbst_pkg::*; (
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fbst_sweep.sv =====
// fbst_sweep: walks the whole store once, reading each source pixel and
// writing it back shifted, with vacated pixels filled; depends on fbst_pkg

module fbst_sweep import fbst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  sweep_cmd_t        cmd,
  input  logic [DATA_W-1:0] bg,
  input  logic [DATA_W-1:0] rdata,
  output logic [ADDR_W-1:0] raddr,
  output mem_wr_t           wr,
  output logic              done
);

  logic              run;
  logic [XW-1:0]     cx;
  logic [YW-1:0]     cy;
  logic              vert;
  logic              desc;
  logic [STEP_W-1:0] amt;
  logic              v1;
  logic              last1;
  logic              fill1;
  logic [ADDR_W-1:0] waddr1;

  logic               last;
  logic               fill;
  logic [X_SUM_W-1:0] x_sum;
  logic [Y_SUM_W-1:0] y_sum;
  logic [XW-1:0]      sx;
  logic [YW-1:0]      sy;

  always_comb begin
    last  = desc ? (cx == '0 && cy == '0)
                 : (cx == XW'(SCREEN_WIDTH - 1) && cy == YW'(SCREEN_HEIGHT - 1));
    x_sum = {1'b0, cx} + X_SUM_W'(amt);
    y_sum = {1'b0, cy} + Y_SUM_W'(amt);
    sx    = cx;
    sy    = cy;
    if (vert) begin
      if (desc) begin
        fill = cy < YW'(amt);
        sy   = cy - YW'(amt);
      end else begin
        fill = y_sum >= Y_SUM_W'(SCREEN_HEIGHT);
        sy   = y_sum[YW-1:0];
      end
    end else begin
      if (desc) begin
        fill = cx < XW'(amt);
        sx   = cx - XW'(amt);
      end else begin
        fill = x_sum >= X_SUM_W'(SCREEN_WIDTH);
        sx   = x_sum[XW-1:0];
      end
    end
    raddr = pix_addr(sx, sy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      v1  <= 1'b0;
    end else begin
      v1 <= run;
      if (go) begin
        run <= 1'b1;
      end else if (run && last) begin
        run <= 1'b0;
      end
    end
  end

  // scan order keeps every source ahead of the write pointer
  always_ff @(posedge clk) begin
    if (go) begin
      vert <= cmd.vert;
      desc <= cmd.desc;
      amt  <= cmd.amount;
      if (cmd.desc) begin
        cx <= XW'(SCREEN_WIDTH - 1);
        cy <= YW'(SCREEN_HEIGHT - 1);
      end else begin
        cx <= '0;
        cy <= '0;
      end
    end else if (run) begin
      if (desc) begin
        if (cx == '0) begin
          cx <= XW'(SCREEN_WIDTH - 1);
          cy <= cy - YW'(1);
        end else begin
          cx <= cx - XW'(1);
        end
      end else begin
        if (cx == XW'(SCREEN_WIDTH - 1)) begin
          cx <= '0;
          cy <= cy + YW'(1);
        end else begin
          cx <= cx + XW'(1);
        end
      end
    end
    last1  <= last;
    fill1  <= fill;
    waddr1 <= pix_addr(cx, cy);
  end

  always_comb begin
    wr.en   = v1;
    wr.addr = waddr1;
    wr.data = fill1 ? bg : rdata;
    done    = v1 && last1;
  end

endmodule

// ===== rtl/core/frame_buffer_slide_transition_unit.sv =====
// Frame store with a slide engine. A transaction is accepted when start is high and
// busy is low; each result shows on the result ports for one cycle with done high,
// and the receiver cannot stall it. A pixel write (busy stays low), a start or a tick
// that moves nothing raises done in the next cycle; a read passes through ST_READ
// first. A tick that moves the picture holds busy high in ST_SWEEP while the sweep
// reads and rewrites every pixel once through the single write port of the store.
// Offsets and transition_active are valid whenever done is high.
// depends on fbst_pkg, fbst_store, fbst_sweep

module frame_buffer_slide_transition_unit import fbst_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        command,
  input  logic [6:0]        pixel_x,
  input  logic [6:0]        pixel_y,
  input  logic [15:0]       pixel_value,
  input  logic [2:0]        slide_direction,
  output logic              busy,
  output logic              done,
  output logic [15:0]       read_value,
  output logic signed [8:0] offset_x,
  output logic signed [8:0] offset_y,
  output logic              transition_active,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  localparam logic REG_BG = 1'b0;

  logic [1:0]        state;
  logic [DATA_W-1:0] bg;
  logic [2:0]        dir;
  logic [IDX_W-1:0]  idx;
  logic [OFS_W-1:0]  h_off;
  logic [OFS_W-1:0]  v_off;
  logic              rd_inside;

  logic              accept;
  logic              pix_inside;
  logic [ADDR_W-1:0] pix_a;
  logic              horiz;
  logic              moving;
  logic              in_table;
  logic              pending;
  logic              do_shift;
  logic [STEP_W-1:0] step;
  sweep_cmd_t        sweep_cmd;
  logic              eng_go;
  logic              eng_done;
  logic [ADDR_W-1:0] eng_raddr;
  mem_wr_t           eng_wr;
  mem_wr_t           mem_wr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] rdata;
  logic              cfg_wr;

  assign busy              = state != ST_IDLE;
  assign accept            = start && !busy;
  assign offset_x          = $signed(h_off);
  assign offset_y          = $signed(v_off);
  assign transition_active = dir != DIR_NONE;
  assign pready            = 1'b1;
  assign cfg_wr            = psel && penable && pwrite;
  assign prdata            = (paddr[2] == REG_BG) ? {16'b0, bg} : 32'b0;

  assign pix_inside = (int'(pixel_x) < SCREEN_WIDTH) && (int'(pixel_y) < SCREEN_HEIGHT);
  assign pix_a      = pix_addr(XW'(pixel_x), YW'(pixel_y));

  always_comb begin
    horiz    = (dir == DIR_LEFT) || (dir == DIR_RIGHT);
    moving   = horiz || (dir == DIR_UP) || (dir == DIR_DOWN);
    in_table = idx < (horiz ? IDX_W'(H_STEPS) : IDX_W'(V_STEPS));
    step     = in_table ? (horiz ? h_step(idx) : v_step(idx)) : STEP_W'(1);
    case (dir)
      DIR_LEFT:  pending = !h_off[OFS_W-1] && (h_off != '0);
      DIR_RIGHT: pending = h_off[OFS_W-1];
      DIR_UP:    pending = !v_off[OFS_W-1] && (v_off != '0);
      DIR_DOWN:  pending = v_off[OFS_W-1];
      default:   pending = 1'b0;
    endcase
    do_shift         = moving && (in_table || pending);
    sweep_cmd.vert   = !horiz;
    sweep_cmd.desc   = (dir == DIR_RIGHT) || (dir == DIR_DOWN);
    sweep_cmd.amount = step;
    eng_go           = accept && (command == CMD_TICK) && do_shift;
  end

  always_comb begin
    if (eng_wr.en) begin
      mem_wr = eng_wr;
    end else begin
      mem_wr.en   = accept && (command == CMD_WRITE) && pix_inside;
      mem_wr.addr = pix_a;
      mem_wr.data = pixel_value;
    end
    mem_raddr = (state == ST_SWEEP) ? eng_raddr : pix_a;
  end

  fbst_store u_store (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  fbst_sweep u_sweep (
    .clk   (clk),
    .rst   (rst),
    .go    (eng_go),
    .cmd   (sweep_cmd),
    .bg    (bg),
    .rdata (rdata),
    .raddr (eng_raddr),
    .wr    (eng_wr),
    .done  (eng_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bg    <= '0;
      dir   <= DIR_NONE;
      idx   <= '0;
      h_off <= '0;
      v_off <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_wr && paddr[2] == REG_BG) begin
        bg <= pwdata[DATA_W-1:0];
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              CMD_WRITE: begin
                done       <= 1'b1;
                read_value <= '0;
              end
              CMD_READ: begin
                rd_inside <= pix_inside;
                state     <= ST_READ;
              end
              CMD_START: begin
                done       <= 1'b1;
                read_value <= '0;
                idx        <= '0;
                h_off      <= '0;
                v_off      <= '0;
                dir        <= DIR_NONE;
                case (slide_direction)
                  DIR_LEFT: begin
                    h_off <= OFS_W'(SCREEN_WIDTH);
                    dir   <= DIR_LEFT;
                  end
                  DIR_RIGHT: begin
                    h_off <= OFS_W'(-SCREEN_WIDTH);
                    dir   <= DIR_RIGHT;
                  end
                  DIR_UP: begin
                    v_off <= OFS_W'(SCREEN_HEIGHT);
                    dir   <= DIR_UP;
                  end
                  DIR_DOWN: begin
                    v_off <= OFS_W'(-SCREEN_HEIGHT);
                    dir   <= DIR_DOWN;
                  end
                  default: begin
                    dir <= DIR_NONE;
                  end
                endcase
              end
              default: begin
                read_value <= '0;
                if (do_shift) begin
                  state <= ST_SWEEP;
                  if (in_table) begin
                    idx <= idx + IDX_W'(1);
                  end
                  case (dir)
                    DIR_LEFT:  h_off <= h_off - OFS_W'(step);
                    DIR_RIGHT: h_off <= h_off + OFS_W'(step);
                    DIR_UP:    v_off <= v_off - OFS_W'(step);
                    default:   v_off <= v_off + OFS_W'(step);
                  endcase
                end else begin
                  done <= 1'b1;
                  if (moving) begin
                    dir <= DIR_NONE;
                    if (horiz) begin
                      h_off <= '0;
                    end else begin
                      v_off <= '0;
                    end
                  end
                end
              end
            endcase
          end
        end
        ST_READ: begin
          done       <= 1'b1;
          read_value <= rd_inside ? rdata : '0;
          state      <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (eng_done) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
